/* hdl/drcd_pkg.sv */
// ----------------------------------------------------------------------------
// drcd_pkg
// Shared types, codes and constants of the debounced rate counter display.
// ----------------------------------------------------------------------------
package drcd_pkg;

    // field widths
    localparam int unsigned OP_W     = 2;
    localparam int unsigned LOAD_W   = 14;
    localparam int unsigned COUNT_W  = 14;
    localparam int unsigned PERIOD_W = 11;
    localparam int unsigned STEP_W   = 9;
    localparam int unsigned TICKS_W  = 5;
    localparam int unsigned SEG_W    = 7;
    localparam int unsigned DIGITS   = 4;
    localparam int unsigned SCAN_W   = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 11;

    // event codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_LOAD   = 2'd1,
        OP_STOP   = 2'd2,
        OP_RESUME = 2'd3
    } t_op;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MAX     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd3;

    // reset values
    localparam logic [STEP_W-1:0]   RST_PERIOD_STEP    = 9'd50;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_MIN     = 11'd50;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_MAX     = 11'd2000;
    localparam logic [TICKS_W-1:0]  RST_DEBOUNCE_TICKS = 5'd20;

    // limits
    localparam logic [COUNT_W-1:0]  COUNT_MOD   = 14'd10000;
    localparam logic [PERIOD_W-1:0] ELAPSED_MAX = 11'd2047;
    localparam logic [TICKS_W-1:0]  QUIET_MAX   = 5'd31;

    typedef struct packed {
        t_op               op;
        logic              button_left;
        logic              button_right;
        logic [LOAD_W-1:0] load_value;
    } t_item;

    typedef struct packed {
        logic [STEP_W-1:0]   period_step;
        logic [PERIOD_W-1:0] period_min;
        logic [PERIOD_W-1:0] period_max;
        logic [TICKS_W-1:0]  debounce_ticks;
    } t_cfg;

    typedef struct packed {
        logic [SEG_W-1:0]    segments;
        logic [DIGITS-1:0]   digit_enable_n;
        logic [COUNT_W-1:0]  count_value;
        logic [PERIOD_W-1:0] period_ms;
    } t_result;

    // seven-segment pattern, bit0 is segment a
    function automatic logic [SEG_W-1:0] f_seg(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0: seg = 7'h3F;
            4'd1: seg = 7'h06;
            4'd2: seg = 7'h5B;
            4'd3: seg = 7'h4F;
            4'd4: seg = 7'h66;
            4'd5: seg = 7'h6D;
            4'd6: seg = 7'h7D;
            4'd7: seg = 7'h07;
            4'd8: seg = 7'h7F;
            4'd9: seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

/* hdl/drcd_debounce.sv */
// ----------------------------------------------------------------------------
// drcd_debounce
// Stability counter for one raw button level, flags a debounced press.
// ----------------------------------------------------------------------------
module drcd_debounce (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_raw,
    input  logic [drcd_pkg::TICKS_W-1:0]  i_ticks,
    output logic                          o_press
);
    import drcd_pkg::*;

    logic               r_prev;
    logic               r_stable;
    logic [TICKS_W-1:0] r_quiet;
    logic [TICKS_W-1:0] n_quiet;
    logic               w_take;

    // quiet counter restarts on a level change, saturates otherwise
    always_comb begin
        if (i_raw != r_prev) begin
            n_quiet = '0;
        end else if (r_quiet != QUIET_MAX) begin
            n_quiet = r_quiet + 1'b1;
        end else begin
            n_quiet = r_quiet;
        end
        w_take  = (n_quiet >= i_ticks) && (i_raw != r_stable);
        o_press = w_take && !i_raw;
    end

    // level history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 1'b1;
            r_stable <= 1'b1;
            r_quiet  <= '0;
        end else if (i_en) begin
            r_prev  <= i_raw;
            r_quiet <= n_quiet;
            if (w_take) begin
                r_stable <= i_raw;
            end
        end
    end

endmodule

/* hdl/drcd_core.sv */
// ----------------------------------------------------------------------------
// drcd_core
// Counter, period and scan state with the single-pass update of one word.
// ----------------------------------------------------------------------------
module drcd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  drcd_pkg::t_item   i_item,
    input  drcd_pkg::t_cfg    i_cfg,
    output drcd_pkg::t_result o_result
);
    import drcd_pkg::*;

    // pick one decimal digit of a value below ten thousand by threshold compares
    function automatic logic [3:0] f_digit(input logic [COUNT_W-1:0] v,
                                           input logic [SCAN_W-1:0] idx);
        logic [3:0] th;
        logic [3:0] hu;
        logic [3:0] te;
        logic [9:0] r1;
        logic [6:0] r2;
        logic [3:0] r3;
        logic [3:0] d;
        th = '0;
        hu = '0;
        te = '0;
        r1 = v[9:0];
        for (int k = 1; k < 10; k++) begin
            if (v >= 14'(k * 1000)) begin
                th = 4'(k);
                r1 = 10'(v - 14'(k * 1000));
            end
        end
        r2 = r1[6:0];
        for (int k = 1; k < 10; k++) begin
            if (r1 >= 10'(k * 100)) begin
                hu = 4'(k);
                r2 = 7'(r1 - 10'(k * 100));
            end
        end
        r3 = r2[3:0];
        for (int k = 1; k < 10; k++) begin
            if (r2 >= 7'(k * 10)) begin
                te = 4'(k);
                r3 = 4'(r2 - 7'(k * 10));
            end
        end
        case (idx)
            2'd0:    d = th;
            2'd1:    d = hu;
            2'd2:    d = te;
            default: d = r3;
        endcase
        return d;
    endfunction

    logic [COUNT_W-1:0]  r_count;
    logic                r_running;
    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] r_elapsed;
    logic [SCAN_W-1:0]   r_scan;

    logic                w_tick;
    logic                w_press_l;
    logic                w_press_r;
    logic [PERIOD_W:0]   w_sum_l;
    logic [PERIOD_W-1:0] w_per_l;
    logic [PERIOD_W:0]   w_floor;
    logic [PERIOD_W-1:0] w_per_r;
    logic [PERIOD_W-1:0] w_elapsed;
    logic                w_fire;
    logic [COUNT_W-1:0]  w_count_sum;
    logic [COUNT_W-1:0]  w_count_step;
    logic [COUNT_W-1:0]  w_load;
    logic [3:0]          w_digit;

    assign w_tick = i_adv && (i_item.op == OP_TICK);

    drcd_debounce u_dbnc_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_tick),
        .i_raw   (i_item.button_left),
        .i_ticks (i_cfg.debounce_ticks),
        .o_press (w_press_l)
    );

    drcd_debounce u_dbnc_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_tick),
        .i_raw   (i_item.button_right),
        .i_ticks (i_cfg.debounce_ticks),
        .o_press (w_press_r)
    );

    // period: left press lengthens up to the ceiling, right press shortens to the floor
    always_comb begin
        w_sum_l = {1'b0, r_period} + {3'b000, i_cfg.period_step};
        if (!w_press_l) begin
            w_per_l = r_period;
        end else if (w_sum_l > {1'b0, i_cfg.period_max}) begin
            w_per_l = i_cfg.period_max;
        end else begin
            w_per_l = w_sum_l[PERIOD_W-1:0];
        end
        w_floor = {1'b0, i_cfg.period_min} + {3'b000, i_cfg.period_step};
        if (!w_press_r) begin
            w_per_r = w_per_l;
        end else if ({1'b0, w_per_l} < w_floor) begin
            w_per_r = i_cfg.period_min;
        end else begin
            w_per_r = w_per_l - {2'b00, i_cfg.period_step};
        end
    end

    // elapsed time and count step to the next even value
    always_comb begin
        w_elapsed = (r_elapsed != ELAPSED_MAX) ? r_elapsed + 1'b1 : r_elapsed;
        w_fire    = r_running && (w_elapsed >= w_per_r);
        w_count_sum  = r_count + (r_count[0] ? 14'd1 : 14'd2);
        w_count_step = (w_count_sum >= COUNT_MOD) ? w_count_sum - COUNT_MOD
                                                  : w_count_sum;
        w_load = (i_item.load_value >= COUNT_MOD) ? i_item.load_value - COUNT_MOD
                                                  : i_item.load_value;
    end

    // display scan of the count before this tick's step; count and period outputs after it
    always_comb begin
        w_digit                 = f_digit(r_count, r_scan);
        o_result.segments       = f_seg(w_digit);
        o_result.digit_enable_n = ~(4'b0001 << r_scan);
        o_result.count_value    = w_fire ? w_count_step : r_count;
        o_result.period_ms      = w_per_r;
    end

    // state update per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_running <= 1'b0;
            r_period  <= RST_PERIOD_MAX;
            r_elapsed <= '0;
            r_scan    <= '0;
        end else if (i_adv) begin
            case (i_item.op)
                OP_TICK: begin
                    r_period <= w_per_r;
                    r_scan   <= r_scan + 1'b1;
                    if (w_fire) begin
                        r_count   <= w_count_step;
                        r_elapsed <= '0;
                    end else begin
                        r_elapsed <= w_elapsed;
                    end
                end
                OP_LOAD: begin
                    r_count   <= w_load;
                    r_running <= 1'b1;
                end
                OP_STOP: begin
                    r_running <= 1'b0;
                end
                OP_RESUME: begin
                    r_running <= 1'b1;
                end
                default: begin
                    r_running <= r_running;
                end
            endcase
        end
    end

endmodule

/* hdl/debounced_rate_counter_display_top.sv */
// ----------------------------------------------------------------------------
// debounced_rate_counter_display_top
// Event-driven counter with debounced period buttons and a scanned
// four-digit seven-segment display.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 words
//  in        input      i_in_valid / o_in_ready   op, buttons, load value
//  out       output     o_out_valid / i_out_ready segments, digit select, count, period
//  cfg       input      i_cfg_we                  register index and data
//
//  one word per cycle while no tick waits; a tick result is written to the result register
//  at the same edge at which the word leaves the input register
//  throughput is set by the input register and the result register
//  load, stop and resume words pass without a result and never wait on out
//  a tick word waits in the input register while the result register holds
//  a word that is not taken
//  synchronous active-low reset empties the input and result registers and resets the core, config returns to defaults
// ----------------------------------------------------------------------------
module debounced_rate_counter_display_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write port
    input  logic                             i_cfg_we,
    input  logic [drcd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [drcd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input words
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [drcd_pkg::OP_W-1:0]        i_op,
    input  logic                             i_button_left,
    input  logic                             i_button_right,
    input  logic [drcd_pkg::LOAD_W-1:0]      i_load_value,
    // result words
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [drcd_pkg::SEG_W-1:0]       o_segments,
    output logic [drcd_pkg::DIGITS-1:0]      o_digit_enable_n,
    output logic [drcd_pkg::COUNT_W-1:0]     o_count_value,
    output logic [drcd_pkg::PERIOD_W-1:0]    o_period_ms
);
    import drcd_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result w_result;
    logic    w_adv;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_step    <= RST_PERIOD_STEP;
            r_cfg.period_min     <= RST_PERIOD_MIN;
            r_cfg.period_max     <= RST_PERIOD_MAX;
            r_cfg.debounce_ticks <= RST_DEBOUNCE_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PERIOD_STEP:    r_cfg.period_step    <= i_cfg_data[STEP_W-1:0];
                CFG_PERIOD_MIN:     r_cfg.period_min     <= i_cfg_data[PERIOD_W-1:0];
                CFG_PERIOD_MAX:     r_cfg.period_max     <= i_cfg_data[PERIOD_W-1:0];
                CFG_DEBOUNCE_TICKS: r_cfg.debounce_ticks <= i_cfg_data[TICKS_W-1:0];
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    // a word leaves the input register unless it is a tick facing a full result
    assign w_adv      = r_in_valid &&
                        ((r_in.op != OP_TICK) || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.op           <= t_op'(i_op);
            r_in.button_left  <= i_button_left;
            r_in.button_right <= i_button_right;
            r_in.load_value   <= i_load_value;
        end
    end

    drcd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && (r_in.op == OP_TICK)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && (r_in.op == OP_TICK)) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_segments       = r_out.segments;
    assign o_digit_enable_n = r_out.digit_enable_n;
    assign o_count_value    = r_out.count_value;
    assign o_period_ms      = r_out.period_ms;

endmodule

/* hdl/drcd_checker.sv */
// ----------------------------------------------------------------------------
// drcd_checker
// Port-level checks of the counter display, bound to the top level.
// ----------------------------------------------------------------------------
module drcd_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  logic [drcd_pkg::DIGITS-1:0]      o_digit_enable_n,
    input  logic [drcd_pkg::COUNT_W-1:0]     o_count_value
);
    import drcd_pkg::*;

    // a pending result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    // exactly one digit is selected
    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot(~o_digit_enable_n))
        else $error("digit select is not one-cold");

    // count stays in its decimal range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_count_value < COUNT_MOD))
        else $error("count out of range");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind debounced_rate_counter_display_top drcd_checker u_drcd_checker (.*);
